>>> rtl/bsr_pkg.sv
// ============================================================================
// Byte stream reassembler package
// Shared sizes, beat payload types, controller states and the command and
// status groups that pass between the controller and the datapath.
// ============================================================================
`default_nettype none

package bsr_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic [31:0] stream_position;
		logic        has_byte;
		logic        end_of_stream;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       last;
		logic [6:0] held_count;
		logic       stream_ended;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SETTLE,
		ST_LOAD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic take;         // store the input beat
		logic scan;         // release the head slot and slide the window
		logic settle;       // update the ended flag
		logic rd;           // read the next released byte from the store
		logic load_status;  // present a status-only result
		logic load_byte;    // present the byte just read
	} cmd_t;

	typedef struct packed {
		logic scan_more;    // head slot filled and the run is not yet full
		logic run_zero;     // no released byte left to present
	} status_t;

	// Step a window index forward, wrapping at the window size.
	function automatic idx_t idx_inc(input idx_t i);
		idx_t r;
		if (i == idx_t'(CAPACITY - 1)) begin
			r = '0;
		end else begin
			r = i + idx_t'(1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/bsr_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module bsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/bsr_ctrl.sv
// ============================================================================
// Reassembler controller
// Sequences intake, the release scan, the ended update and the result beats.
// ============================================================================
`default_nettype none

module bsr_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire bsr_pkg::status_t st,
	output bsr_pkg::cmd_t         cmd
);

	import bsr_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (st.scan_more) begin
					cmd.scan = 1'b1;
				end else begin
					state_d = ST_SETTLE;
				end
			end
			ST_SETTLE: begin
				cmd.settle = 1'b1;
				if (st.run_zero) begin
					cmd.load_status = 1'b1;
					state_d         = ST_OUT;
				end else begin
					cmd.rd  = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load_byte = 1'b1;
				state_d       = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (st.run_zero) begin
						state_d = ST_IDLE;
					end else begin
						cmd.rd  = 1'b1;
						state_d = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/bsr_dp.sv
// ============================================================================
// Reassembler datapath
// Window store, filled marks, stream position, end tracking and result
// register, all driven by controller commands.
// ============================================================================
`default_nettype none

module bsr_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bsr_pkg::in_beat_t in_data,
	input  wire bsr_pkg::cmd_t     cmd,
	output bsr_pkg::status_t       st,
	output bsr_pkg::out_beat_t     out_data
);

	import bsr_pkg::*;

	logic [CAPACITY-1:0] filled_q;
	idx_t                head_q;
	idx_t                emit_q;
	cnt_t                run_q;
	logic [31:0]         next_q;
	logic [6:0]          held_q;
	logic                end_known_q;
	logic [31:0]         end_pos_q;
	logic                ended_q;
	out_beat_t           out_q;

	logic [31:0]  offset;
	logic         in_window;
	logic [IDX_W:0] slot_sum;
	idx_t         slot;
	logic         store_it;
	logic [31:0]  end_in;
	logic         ended_d;
	logic [7:0]   rd_byte;

	assign offset    = in_data.stream_position - next_q;
	assign in_window = (offset < 32'(CAPACITY));
	assign slot_sum  = {1'b0, head_q} + {1'b0, offset[IDX_W-1:0]};
	assign slot      = (slot_sum >= (IDX_W+1)'(CAPACITY))
		? idx_t'(slot_sum - (IDX_W+1)'(CAPACITY)) : idx_t'(slot_sum);
	assign store_it  = in_data.has_byte && in_window && !filled_q[slot];
	assign end_in    = in_data.stream_position + {31'd0, in_data.has_byte};
	assign ended_d   = ended_q || (end_known_q && (end_pos_q == next_q));

	assign st.scan_more = filled_q[head_q] && (run_q != cnt_t'(CAPACITY));
	assign st.run_zero  = (run_q == '0);

	bsr_ram #(
		.WIDTH (8),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (cmd.take && store_it),
		.waddr (slot),
		.wdata (in_data.byte_value),
		.re    (cmd.rd),
		.raddr (emit_q),
		.rdata (rd_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q    <= '0;
			head_q      <= '0;
			emit_q      <= '0;
			run_q       <= '0;
			next_q      <= '0;
			held_q      <= '0;
			end_known_q <= 1'b0;
			end_pos_q   <= '0;
			ended_q     <= 1'b0;
		end else begin
			if (cmd.take) begin
				emit_q <= head_q;
				run_q  <= '0;
				if (store_it) begin
					filled_q[slot] <= 1'b1;
					held_q         <= held_q + 7'd1;
				end
				if (in_data.end_of_stream && (in_window || (end_in == next_q))) begin
					end_known_q <= 1'b1;
					end_pos_q   <= end_in;
				end
			end
			if (cmd.scan) begin
				filled_q[head_q] <= 1'b0;
				head_q           <= idx_inc(head_q);
				next_q           <= next_q + 32'd1;
				held_q           <= held_q - 7'd1;
				run_q            <= run_q + cnt_t'(1);
			end
			if (cmd.settle) begin
				ended_q <= ended_d;
			end
			if (cmd.rd) begin
				emit_q <= idx_inc(emit_q);
				run_q  <= run_q - cnt_t'(1);
			end
		end
	end

	// Result register; the payload needs no reset.
	always_ff @(posedge clk) begin
		if (cmd.load_status) begin
			out_q.out_byte     <= 8'd0;
			out_q.out_valid    <= 1'b0;
			out_q.last         <= 1'b1;
			out_q.held_count   <= held_q;
			out_q.stream_ended <= ended_d;
		end else if (cmd.load_byte) begin
			out_q.out_byte     <= rd_byte;
			out_q.out_valid    <= 1'b1;
			out_q.last         <= st.run_zero;
			out_q.held_count   <= held_q;
			out_q.stream_ended <= ended_q;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

>>> rtl/byte_stream_reassembler_top.sv
// ============================================================================
// Byte stream reassembler
// Puts out-of-order stream bytes back in order and releases the in-order run.
// ============================================================================
// Each input beat carries at most one byte with its absolute 32-bit stream
// position. The block holds a window of CAPACITY slots starting at the next
// position expected in order; a byte outside the window, or one landing on a
// slot that is already filled, is dropped. An end-of-stream beat records the
// end position (one past its byte, or the position itself for an empty
// segment), and the stream is reported ended once every byte before that
// position has been released. After each input beat the filled run at the
// head of the window is released as one result beat per byte, in order, the
// final one marked last; when nothing is released a single status-only beat
// with out_valid low is given. Every result beat carries the held count and
// the ended flag as they stand after the whole input beat. One input beat is
// handled at a time: the block is not ready for the next one until the last
// result beat has been taken, so the output side can hold it off. The release
// scan steps through the filled marks one slot per cycle, and the window
// store has a single read port, so each released byte is read and registered
// before its beat is presented, one byte at a time. The window is a circular
// buffer, so no data moves as it slides, and the filled marks are flip-flops
// cleared by reset, so no clearing pass is needed.
// ============================================================================
`default_nettype none

module byte_stream_reassembler_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire bsr_pkg::in_beat_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output bsr_pkg::out_beat_t      out_data
);

	import bsr_pkg::*;

	cmd_t    cmd;
	status_t st;

	// The controller owns both handshakes and drives the command group every cycle.
	bsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// The datapath holds the window, the stream position and the result
	// register that is presented while out_valid is high.
	bsr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.st       (st),
		.out_data (out_data)
	);

endmodule

`default_nettype wire
